// File: hdl/jtdd_pkg.sv
`default_nettype none

package jtdd_pkg;

    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 16;
    localparam int DZ_W     = 15;

    localparam int MUL_AW   = 33;
    localparam int MUL_BW   = 16;
    localparam int MUL_PW   = MUL_AW + MUL_BW;

    localparam int LIN_SHIFT   = 17;
    localparam int WHEEL_SHIFT = 36;

    typedef enum logic [CFG_IW-1:0] {
        CFG_DEADZONE    = 3'd0,
        CFG_LOW_SCALE   = 3'd1,
        CFG_MID_SCALE   = 3'd2,
        CFG_HIGH_SCALE  = 3'd3,
        CFG_ANG_SCALE   = 3'd4,
        CFG_HALF_TRACK  = 3'd5,
        CFG_RPM_PER_MPS = 3'd6
    } cfg_idx_t;

    localparam logic [DZ_W-1:0]   RST_DEADZONE    = 15'd3277;
    localparam logic [15:0]       RST_LOW_SCALE   = 16'd5734;
    localparam logic [15:0]       RST_MID_SCALE   = 16'd10650;
    localparam logic [15:0]       RST_HIGH_SCALE  = 16'd19661;
    localparam logic [15:0]       RST_ANG_SCALE   = 16'd9830;
    localparam logic [15:0]       RST_HALF_TRACK  = 16'd15073;
    localparam logic [15:0]       RST_RPM_PER_MPS = 16'd256;

    localparam logic [1:0] GEAR_LOW  = 2'd1;
    localparam logic [1:0] GEAR_MID  = 2'd2;
    localparam logic [1:0] GEAR_HIGH = 2'd3;

    localparam int BTN_N      = 6;
    localparam int BTN_MODE   = 0;
    localparam int BTN_LOCK   = 1;
    localparam int BTN_ENABLE = 2;
    localparam int BTN_LOW    = 3;
    localparam int BTN_MID    = 4;
    localparam int BTN_HIGH   = 5;

    typedef logic signed [MUL_AW-1:0] mul_a_t;
    typedef logic signed [MUL_PW-1:0] mul_p_t;

    typedef struct packed {
        logic               command;
        logic               mode_button;
        logic               lock_button;
        logic               deadman_button;
        logic               low_gear_button;
        logic               mid_gear_button;
        logic               high_gear_button;
        logic signed [15:0] joy_linear;
        logic signed [15:0] joy_angular;
        logic signed [15:0] cmd_linear;
        logic signed [15:0] cmd_angular;
    } in_beat_t;

    typedef struct packed {
        logic signed [15:0] left_wheel_rpm;
        logic signed [15:0] right_wheel_rpm;
        logic               motors_on;
        logic               is_manual;
        logic [1:0]         gear;
    } out_beat_t;

endpackage

`default_nettype wire

// File: hdl/jtdd_smul.sv
`default_nettype none

// bit-serial signed x unsigned multiplier, one multiplier bit per cycle, LSB first
module jtdd_smul #(
    parameter int AW = 33,
    parameter int BW = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [AW-1:0]    a,
    input  wire logic [BW-1:0]           b,
    output logic                         done,
    output logic signed [AW+BW-1:0]      product
);

    localparam int CW = (BW > 1) ? $clog2(BW) : 1;

    logic signed [AW-1:0] a_reg;
    logic [BW-1:0]        b_reg;
    logic signed [AW:0]   acc_reg;
    logic [BW-1:0]        lo_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [AW:0]   sum;

    assign sum = acc_reg + (b_reg[0] ? {a_reg[AW-1], a_reg} : {(AW+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(BW - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
            lo_reg  <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= sum >>> 1;
            lo_reg  <= {sum[0], lo_reg[BW-1:1]};
            b_reg   <= b_reg >> 1;
        end
    end

    assign done    = done_reg;
    assign product = {acc_reg[AW-1:0], lo_reg};

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("multiplier restarted while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (!busy_reg && $past(busy_reg)))
        else $error("done without a preceding busy cycle");

    a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && cnt_reg == '0) |=> done_reg)
        else $error("final step did not raise done");

endmodule

`default_nettype wire

// File: hdl/joystick_teleop_diff_drive.sv
// Joystick teleoperation front end for a differential-drive base.
// in_valid/in_ready/in_data carry one beat per joystick report or autonomous
// velocity command; out_valid/out_ready/out_data carry at most one wheel-speed
// beat per input beat. cfg_we/cfg_index/cfg_data write the seven settings,
// taken at once; the user must write them only while the block is idle, as
// the block itself does not enforce this. Arithmetic runs on two bit-serial
// multipliers, one bit per cycle. A joystick report takes three passes (axis
// scaling, turn term, wheel scaling); an autonomous command skips the axis
// pass. A new beat is taken only once the last result has gone to the output
// register. A blocked autonomous command gives no beat and is dropped on acceptance.
// The output register lets the next beat be accepted while a result waits;
// if the receiver is still stalled when the next result is ready, the block
// holds it and takes no new beat until the output frees.
// Reset: manual mode, motors off, mid gear, no button history, default
// settings, output empty.
`default_nettype none

module joystick_teleop_diff_drive (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire jtdd_pkg::in_beat_t            in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output jtdd_pkg::out_beat_t                out_data,
    input  wire logic                          cfg_we,
    input  wire logic [jtdd_pkg::CFG_IW-1:0]   cfg_index,
    input  wire logic [jtdd_pkg::CFG_DW-1:0]   cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXIS,
        ST_TURN,
        ST_WHEEL,
        ST_DONE
    } state_t;

    // settings
    logic [jtdd_pkg::DZ_W-1:0] deadzone_reg;
    logic [15:0] low_scale_reg, mid_scale_reg, high_scale_reg;
    logic [15:0] ang_scale_reg, half_track_reg, rpm_per_mps_reg;

    state_t                    state_reg;
    logic                      manual_reg, motor_reg;
    logic [1:0]                gear_reg;
    logic [jtdd_pkg::BTN_N-1:0] prev_btn_reg;
    logic signed [15:0]        lin_reg;
    logic signed [15:0]        left_reg, right_reg;
    logic                      res_motor_reg, res_manual_reg;
    logic [1:0]                res_gear_reg;
    logic                      out_valid_reg;
    jtdd_pkg::out_beat_t       out_data_reg;

    logic [jtdd_pkg::BTN_N-1:0] btn_now, btn_rise;
    logic                      manual_next, motor_next;
    logic [1:0]                gear_next;
    logic                      active;
    logic                      auto_ok;
    logic                      accept;
    logic [15:0]               lin_scale;
    logic [16:0]               mag_lin, mag_ang;
    logic                      pass_lin, pass_ang;

    logic                      x_start, y_start, x_done, y_done;
    jtdd_pkg::mul_a_t          x_a, y_a;
    logic [jtdd_pkg::MUL_BW-1:0] x_b, y_b;
    jtdd_pkg::mul_p_t          x_p, y_p;

    logic signed [15:0]        lin_q, ang_q;
    jtdd_pkg::mul_a_t          base, turn, diff, sum;
    logic signed [16:0]        left_q, right_q, left_neg;

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        if (v > 17'sd32767)
            return 16'sh7fff;
        else if (v < -17'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

    // settings port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deadzone_reg    <= jtdd_pkg::RST_DEADZONE;
            low_scale_reg   <= jtdd_pkg::RST_LOW_SCALE;
            mid_scale_reg   <= jtdd_pkg::RST_MID_SCALE;
            high_scale_reg  <= jtdd_pkg::RST_HIGH_SCALE;
            ang_scale_reg   <= jtdd_pkg::RST_ANG_SCALE;
            half_track_reg  <= jtdd_pkg::RST_HALF_TRACK;
            rpm_per_mps_reg <= jtdd_pkg::RST_RPM_PER_MPS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                jtdd_pkg::CFG_DEADZONE:    deadzone_reg    <= cfg_data[jtdd_pkg::DZ_W-1:0];
                jtdd_pkg::CFG_LOW_SCALE:   low_scale_reg   <= cfg_data;
                jtdd_pkg::CFG_MID_SCALE:   mid_scale_reg   <= cfg_data;
                jtdd_pkg::CFG_HIGH_SCALE:  high_scale_reg  <= cfg_data;
                jtdd_pkg::CFG_ANG_SCALE:   ang_scale_reg   <= cfg_data;
                jtdd_pkg::CFG_HALF_TRACK:  half_track_reg  <= cfg_data;
                jtdd_pkg::CFG_RPM_PER_MPS: rpm_per_mps_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // button edges
    assign btn_now = {in_data.high_gear_button, in_data.mid_gear_button,
                      in_data.low_gear_button, in_data.deadman_button,
                      in_data.lock_button, in_data.mode_button};
    assign btn_rise    = btn_now & ~prev_btn_reg;
    assign manual_next = manual_reg ^ btn_rise[jtdd_pkg::BTN_MODE];
    assign motor_next  = motor_reg ^ (btn_rise[jtdd_pkg::BTN_LOCK] & manual_next);

    always_comb
    begin
        if (btn_rise[jtdd_pkg::BTN_LOW])
            gear_next = jtdd_pkg::GEAR_LOW;
        else if (btn_rise[jtdd_pkg::BTN_MID])
            gear_next = jtdd_pkg::GEAR_MID;
        else if (btn_rise[jtdd_pkg::BTN_HIGH])
            gear_next = jtdd_pkg::GEAR_HIGH;
        else
            gear_next = gear_reg;
    end

    always_comb
    begin
        case (gear_next)
            jtdd_pkg::GEAR_LOW:  lin_scale = low_scale_reg;
            jtdd_pkg::GEAR_HIGH: lin_scale = high_scale_reg;
            default:             lin_scale = mid_scale_reg;
        endcase
    end

    assign active  = motor_next && btn_now[jtdd_pkg::BTN_ENABLE] && manual_next;
    assign auto_ok = motor_reg && !manual_reg;

    // strict deadzone on magnitude
    assign mag_lin = in_data.joy_linear[15] ? (17'd0 - {1'b1, in_data.joy_linear})
                                            : {1'b0, in_data.joy_linear};
    assign mag_ang = in_data.joy_angular[15] ? (17'd0 - {1'b1, in_data.joy_angular})
                                             : {1'b0, in_data.joy_angular};
    assign pass_lin = mag_lin > {2'b00, deadzone_reg};
    assign pass_ang = mag_ang > {2'b00, deadzone_reg};

    // truncate toward zero
    assign lin_q = x_p[jtdd_pkg::LIN_SHIFT+15:jtdd_pkg::LIN_SHIFT]
                 + 16'(x_p[jtdd_pkg::MUL_PW-1] & |x_p[jtdd_pkg::LIN_SHIFT-1:0]);
    assign ang_q = y_p[jtdd_pkg::LIN_SHIFT+15:jtdd_pkg::LIN_SHIFT]
                 + 16'(y_p[jtdd_pkg::MUL_PW-1] & |y_p[jtdd_pkg::LIN_SHIFT-1:0]);

    assign turn = x_p[jtdd_pkg::MUL_AW-1:0];
    assign base = {lin_reg[15], lin_reg, 16'd0};
    assign diff = base - turn;
    assign sum  = base + turn;

    assign left_q  = 17'($signed(x_p[jtdd_pkg::MUL_PW-1:jtdd_pkg::WHEEL_SHIFT]))
                   + 17'(x_p[jtdd_pkg::MUL_PW-1] & |x_p[jtdd_pkg::WHEEL_SHIFT-1:0]);
    assign right_q = 17'($signed(y_p[jtdd_pkg::MUL_PW-1:jtdd_pkg::WHEEL_SHIFT]))
                   + 17'(y_p[jtdd_pkg::MUL_PW-1] & |y_p[jtdd_pkg::WHEEL_SHIFT-1:0]);
    assign left_neg = -left_q;

    // multiplier launch
    always_comb
    begin
        x_start = 1'b0;
        y_start = 1'b0;
        x_a     = '0;
        y_a     = '0;
        x_b     = '0;
        y_b     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !in_data.command)
                begin
                    x_start = 1'b1;
                    y_start = 1'b1;
                    x_a     = (active && pass_lin) ? jtdd_pkg::mul_a_t'(in_data.joy_linear) : '0;
                    y_a     = (active && pass_ang) ? jtdd_pkg::mul_a_t'(in_data.joy_angular) : '0;
                    x_b     = lin_scale;
                    y_b     = ang_scale_reg;
                end
                else if (accept && auto_ok)
                begin
                    x_start = 1'b1;
                    x_a     = jtdd_pkg::mul_a_t'(in_data.cmd_angular);
                    x_b     = half_track_reg;
                end
            end
            ST_AXIS:
            begin
                if (x_done)
                begin
                    x_start = 1'b1;
                    x_a     = jtdd_pkg::mul_a_t'(ang_q);
                    x_b     = half_track_reg;
                end
            end
            ST_TURN:
            begin
                if (x_done)
                begin
                    x_start = 1'b1;
                    y_start = 1'b1;
                    x_a     = diff;
                    y_a     = sum;
                    x_b     = rpm_per_mps_reg;
                    y_b     = rpm_per_mps_reg;
                end
            end
            ST_WHEEL, ST_DONE: ;
            default: ;
        endcase
    end

    jtdd_smul #(
        .AW(jtdd_pkg::MUL_AW),
        .BW(jtdd_pkg::MUL_BW)
    ) u_mul_x (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (x_start),
        .a       (x_a),
        .b       (x_b),
        .done    (x_done),
        .product (x_p)
    );

    jtdd_smul #(
        .AW(jtdd_pkg::MUL_AW),
        .BW(jtdd_pkg::MUL_BW)
    ) u_mul_y (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (y_start),
        .a       (y_a),
        .b       (y_b),
        .done    (y_done),
        .product (y_p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            manual_reg     <= 1'b1;
            motor_reg      <= 1'b0;
            gear_reg       <= jtdd_pkg::GEAR_MID;
            prev_btn_reg   <= '0;
            lin_reg        <= '0;
            left_reg       <= '0;
            right_reg      <= '0;
            res_motor_reg  <= 1'b0;
            res_manual_reg <= 1'b1;
            res_gear_reg   <= jtdd_pkg::GEAR_MID;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && !in_data.command)
                    begin
                        manual_reg     <= manual_next;
                        motor_reg      <= motor_next;
                        gear_reg       <= gear_next;
                        prev_btn_reg   <= btn_now;
                        res_manual_reg <= manual_next;
                        res_motor_reg  <= motor_next;
                        res_gear_reg   <= gear_next;
                        state_reg      <= ST_AXIS;
                    end
                    else if (accept && auto_ok)
                    begin
                        lin_reg        <= in_data.cmd_linear;
                        res_manual_reg <= manual_reg;
                        res_motor_reg  <= motor_reg;
                        res_gear_reg   <= gear_reg;
                        state_reg      <= ST_TURN;
                    end
                end
                ST_AXIS:
                begin
                    if (x_done)
                    begin
                        lin_reg   <= lin_q;
                        state_reg <= ST_TURN;
                    end
                end
                ST_TURN:
                begin
                    if (x_done)
                        state_reg <= ST_WHEEL;
                end
                ST_WHEEL:
                begin
                    if (x_done)
                    begin
                        left_reg  <= sat16(left_neg);
                        right_reg <= sat16(right_q);
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg                <= 1'b1;
                        out_data_reg.left_wheel_rpm  <= left_reg;
                        out_data_reg.right_wheel_rpm <= right_reg;
                        out_data_reg.motors_on       <= res_motor_reg;
                        out_data_reg.is_manual       <= res_manual_reg;
                        out_data_reg.gear            <= res_gear_reg;
                        state_reg                    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_AXIS || state_reg == ST_WHEEL) && x_done) |-> y_done)
        else $error("multiplier lanes out of step");

    a_done_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
        x_done |-> (state_reg == ST_AXIS || state_reg == ST_TURN || state_reg == ST_WHEEL))
        else $error("multiplier finished outside an arithmetic pass");

    a_blocked_auto: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.command && !auto_ok) |=>
            (state_reg == ST_IDLE && $stable(motor_reg) && $stable(manual_reg)
             && $stable(gear_reg)))
        else $error("blocked autonomous command changed state");

    a_gear_valid: assert property (@(posedge clk) disable iff (!rst_n)
        gear_reg != 2'd0)
        else $error("gear left its range");

endmodule

`default_nettype wire

// File: tb/jtdd_rpm_checker.sv
module jtdd_rpm_checker
    import jtdd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire in_beat_t          in_data,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire out_beat_t         out_data,
    input  wire logic              cfg_we,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [CFG_DW-1:0] cfg_data,
    output int                     fail_count,
    output int                     pending,
    output int                     checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [DZ_W-1:0]  dz_reg;
    logic [15:0]      low_reg;
    logic [15:0]      mid_reg;
    logic [15:0]      high_reg;
    logic [15:0]      ang_reg;
    logic [15:0]      track_reg;
    logic [15:0]      rpm_reg;

    logic             manual_q;
    logic             motors_q;
    logic [1:0]       gear_q;
    logic [BTN_N-1:0] prev_btn;

    out_beat_t        expected_wheel_q[$];

    function automatic logic signed [15:0] clamp_rpm(longint v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    // stick axis to Q3.12 speed; magnitude must exceed the deadzone
    function automatic int stick_speed(logic signed [15:0] axis, logic [15:0] scale);
        int     mag;
        longint prod;
        mag = (axis < 0) ? -int'(axis) : int'(axis);
        if (mag <= int'(dz_reg))
            return 0;
        prod = longint'(axis) * longint'({1'b0, scale});
        return int'(prod / (longint'(1) << LIN_SHIFT));
    endfunction

    function automatic out_beat_t wheel_rpm_beat(int lin, int ang);
        out_beat_t b;
        longint    base;
        longint    turn;
        longint    k;
        longint    left;
        longint    right;
        base  = longint'(lin) * 65536;
        turn  = longint'(ang) * longint'({1'b0, track_reg});
        k     = longint'({1'b0, rpm_reg});
        left  = ((base - turn) * k) / (longint'(1) << WHEEL_SHIFT);
        right = ((base + turn) * k) / (longint'(1) << WHEEL_SHIFT);
        b.left_wheel_rpm  = clamp_rpm(-left);
        b.right_wheel_rpm = clamp_rpm(right);
        b.motors_on = motors_q;
        b.is_manual = manual_q;
        b.gear      = gear_q;
        return b;
    endfunction

    task automatic take_beat(in_beat_t b);
        logic [BTN_N-1:0] now_btn;
        logic [BTN_N-1:0] rise;
        logic [15:0]      lin_scale;
        int               lin;
        int               ang;
        if (b.command)
        begin
            if (motors_q && !manual_q)
                expected_wheel_q.push_back(wheel_rpm_beat(b.cmd_linear, b.cmd_angular));
        end
        else
        begin
            now_btn[BTN_MODE]   = b.mode_button;
            now_btn[BTN_LOCK]   = b.lock_button;
            now_btn[BTN_ENABLE] = b.deadman_button;
            now_btn[BTN_LOW]    = b.low_gear_button;
            now_btn[BTN_MID]    = b.mid_gear_button;
            now_btn[BTN_HIGH]   = b.high_gear_button;
            rise = now_btn & ~prev_btn;
            // mode first, so the lock edge sees the new mode
            if (rise[BTN_MODE])
                manual_q = !manual_q;
            if (rise[BTN_LOCK] && manual_q)
                motors_q = !motors_q;
            if (rise[BTN_LOW])
                gear_q = GEAR_LOW;
            else if (rise[BTN_MID])
                gear_q = GEAR_MID;
            else if (rise[BTN_HIGH])
                gear_q = GEAR_HIGH;
            prev_btn = now_btn;
            lin = 0;
            ang = 0;
            if (motors_q && now_btn[BTN_ENABLE] && manual_q)
            begin
                lin_scale = (gear_q == GEAR_LOW)  ? low_reg :
                            (gear_q == GEAR_HIGH) ? high_reg : mid_reg;
                lin = stick_speed(b.joy_linear, lin_scale);
                ang = stick_speed(b.joy_angular, ang_reg);
            end
            expected_wheel_q.push_back(wheel_rpm_beat(lin, ang));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            dz_reg     = RST_DEADZONE;
            low_reg    = RST_LOW_SCALE;
            mid_reg    = RST_MID_SCALE;
            high_reg   = RST_HIGH_SCALE;
            ang_reg    = RST_ANG_SCALE;
            track_reg  = RST_HALF_TRACK;
            rpm_reg    = RST_RPM_PER_MPS;
            manual_q   = 1'b1;
            motors_q   = 1'b0;
            gear_q     = GEAR_MID;
            prev_btn   = '0;
            expected_wheel_q.delete();
            fail_count = 0;
            checked    = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_wheel_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected wheel beat L=%0d R=%0d on=%0b man=%0b g=%0d",
                             $time, out_data.left_wheel_rpm, out_data.right_wheel_rpm,
                             out_data.motors_on, out_data.is_manual, out_data.gear);
                end
                else
                begin
                    want = expected_wheel_q.pop_front();
                    checked++;
                    if (out_data.left_wheel_rpm !== want.left_wheel_rpm
                        || out_data.right_wheel_rpm !== want.right_wheel_rpm
                        || out_data.motors_on !== want.motors_on
                        || out_data.is_manual !== want.is_manual
                        || out_data.gear !== want.gear)
                    begin
                        fail_count++;
                        $display("%0t: mismatch exp L=%0d R=%0d on=%0b man=%0b g=%0d",
                                 $time, want.left_wheel_rpm, want.right_wheel_rpm,
                                 want.motors_on, want.is_manual, want.gear);
                        $display("%0t:          got L=%0d R=%0d on=%0b man=%0b g=%0d",
                                 $time, out_data.left_wheel_rpm, out_data.right_wheel_rpm,
                                 out_data.motors_on, out_data.is_manual, out_data.gear);
                    end
                end
            end
            if (in_valid && in_ready)
                take_beat(in_data);
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_DEADZONE:    dz_reg    = cfg_data[DZ_W-1:0];
                    CFG_LOW_SCALE:   low_reg   = cfg_data;
                    CFG_MID_SCALE:   mid_reg   = cfg_data;
                    CFG_HIGH_SCALE:  high_reg  = cfg_data;
                    CFG_ANG_SCALE:   ang_reg   = cfg_data;
                    CFG_HALF_TRACK:  track_reg = cfg_data;
                    CFG_RPM_PER_MPS: rpm_reg   = cfg_data;
                    default: ;
                endcase
            end
        end
        pending = expected_wheel_q.size();
    end

endmodule

// File: tb/tb_joystick_teleop_diff_drive.sv
module tb_joystick_teleop_diff_drive;
    timeunit 1ns;
    timeprecision 1ps;

    import jtdd_pkg::*;

    localparam logic [BTN_N-1:0] M_MODE = 6'b1 << BTN_MODE;
    localparam logic [BTN_N-1:0] M_LOCK = 6'b1 << BTN_LOCK;
    localparam logic [BTN_N-1:0] M_EN   = 6'b1 << BTN_ENABLE;
    localparam logic [BTN_N-1:0] M_LOW  = 6'b1 << BTN_LOW;
    localparam logic [BTN_N-1:0] M_MID  = 6'b1 << BTN_MID;
    localparam logic [BTN_N-1:0] M_HIGH = 6'b1 << BTN_HIGH;
    localparam int PHASES      = 8;
    localparam int PHASE_BEATS = 141;
    localparam int SETTLE      = 60;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    in_beat_t          in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b1;
    out_beat_t         out_data;
    logic              cfg_we    = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [CFG_DW-1:0] cfg_data  = '0;

    int                fail_count;
    int                pending;
    int                checked;
    int                in_idle_pct   = 0;
    int                out_stall_pct = 0;
    int                cur_dz        = int'(RST_DEADZONE);
    int                sent          = 0;
    logic [BTN_N-1:0]  btn_state     = '0;

    joystick_teleop_diff_drive dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    jtdd_rpm_checker u_rpm_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(0, 99) >= out_stall_pct);

    initial
    begin
        #10_000_000;
        $display("tb_joystick_teleop_diff_drive: FAIL");
        $finish;
    end

    function automatic in_beat_t joy_beat(logic [BTN_N-1:0] btn, int lin, int ang);
        in_beat_t b;
        b.command          = 1'b0;
        b.mode_button      = btn[BTN_MODE];
        b.lock_button      = btn[BTN_LOCK];
        b.deadman_button   = btn[BTN_ENABLE];
        b.low_gear_button  = btn[BTN_LOW];
        b.mid_gear_button  = btn[BTN_MID];
        b.high_gear_button = btn[BTN_HIGH];
        b.joy_linear       = 16'(lin);
        b.joy_angular      = 16'(ang);
        b.cmd_linear       = 16'($urandom);
        b.cmd_angular      = 16'($urandom);
        return b;
    endfunction

    function automatic in_beat_t auto_beat(int lin, int ang);
        in_beat_t b;
        b.command = 1'b1;
        {b.mode_button, b.lock_button, b.deadman_button,
         b.low_gear_button, b.mid_gear_button, b.high_gear_button} = 6'($urandom);
        b.joy_linear  = 16'($urandom);
        b.joy_angular = 16'($urandom);
        b.cmd_linear  = 16'(lin);
        b.cmd_angular = 16'(ang);
        return b;
    endfunction

    // extremes, zero, values either side of the deadzone, otherwise anything
    function automatic int pick_axis(int dz);
        int v;
        case ($urandom_range(0, 5))
            0: v = ($urandom_range(0, 1) != 0) ? 32767 : -32768;
            1: v = 0;
            2:
            begin
                v = dz + int'($urandom_range(0, 1));
                if ($urandom_range(0, 1) != 0)
                    v = -v;
                else if (v > 32767)
                    v = 32767;
            end
            default: v = int'($signed(16'($urandom)));
        endcase
        return v;
    endfunction

    // non-enable levels drift slowly, edges sparse; the odd report is noise
    function automatic logic [BTN_N-1:0] step_buttons(logic [BTN_N-1:0] cur);
        logic [BTN_N-1:0] nxt;
        nxt = cur;
        if ($urandom_range(0, 99) < 10)
            nxt = 6'($urandom);
        else
        begin
            for (int i = 0; i < BTN_N; i++)
            begin
                if (i == BTN_ENABLE)
                    nxt[i] = ($urandom_range(0, 99) < 80);
                else if ($urandom_range(0, 99) < ((i == BTN_LOCK) ? 20 : 15))
                    nxt[i] = !nxt[i];
            end
        end
        return nxt;
    endfunction

    task automatic send_beat(in_beat_t b);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sent++;
    endtask

    task automatic send_random(int count);
        in_beat_t b;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 30)
                b = auto_beat(pick_axis(cur_dz), pick_axis(cur_dz));
            else
            begin
                btn_state = step_buttons(btn_state);
                b = joy_beat(btn_state, pick_axis(cur_dz), pick_axis(cur_dz));
            end
            send_beat(b);
        end
    endtask

    // blocked auto commands leave nothing queued, hence the settle time
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(value);
        @(posedge clk);
    endtask

    task automatic set_regs(int dz, int lo, int mi, int hi, int an, int ht, int rp);
        cur_dz = dz;
        write_reg(CFG_DEADZONE, dz);
        write_reg(CFG_LOW_SCALE, lo);
        write_reg(CFG_MID_SCALE, mi);
        write_reg(CFG_HIGH_SCALE, hi);
        write_reg(CFG_ANG_SCALE, an);
        write_reg(CFG_HALF_TRACK, ht);
        write_reg(CFG_RPM_PER_MPS, rp);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int k;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, manual, motors off, mid gear
        send_beat(joy_beat('0, 0, 0));
        send_beat(auto_beat(100, 100));
        send_beat(joy_beat(M_LOCK, 32767, 32767));
        send_beat(joy_beat(M_EN, 32767, -32768));
        send_beat(joy_beat(M_EN, -32768, 32767));
        send_beat(joy_beat(M_EN | M_LOW | M_MID | M_HIGH, 20000, -20000));
        send_beat(joy_beat(M_EN, 3277, -3277));
        send_beat(joy_beat(M_EN | M_MID | M_HIGH, 3278, -3278));
        send_beat(joy_beat(M_EN, -3278, 3278));
        send_beat(joy_beat(M_EN | M_HIGH, 25000, 12000));
        send_beat(joy_beat(M_EN | M_MODE | M_LOCK, 10000, 10000));
        send_beat(auto_beat(32767, -32768));
        send_beat(auto_beat(-32768, 32767));
        send_beat(joy_beat(M_EN, 10000, 10000));
        send_beat(joy_beat(M_LOCK, 10000, 10000));
        send_beat(joy_beat(M_MODE | M_LOCK, 0, 0));
        send_beat(joy_beat(M_EN, -12345, 23456));
        send_beat(joy_beat(M_LOCK, 0, 0));
        send_beat(joy_beat(M_EN, 30000, 30000));
        send_beat(auto_beat(1000, 1000));
        send_beat(joy_beat(M_MODE, 0, 0));
        send_beat(auto_beat(-2000, 500));
        send_beat(joy_beat('0, 0, 0));
        send_beat(joy_beat(M_MODE, 0, 0));
        btn_state = M_MODE;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_idle();
            case (ph)
                0: set_regs(int'(RST_DEADZONE), int'(RST_LOW_SCALE), int'(RST_MID_SCALE),
                            int'(RST_HIGH_SCALE), int'(RST_ANG_SCALE),
                            int'(RST_HALF_TRACK), int'(RST_RPM_PER_MPS));
                1: set_regs(32767, 65535, 65535, 65535, 65535, 65535, 65535);
                2: set_regs(0, 0, $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), 0, 65535);
                3: set_regs($urandom_range(0, 8000), $urandom_range(0, 65535), 0, 0, 0,
                            65535, $urandom_range(0, 4096));
                4: set_regs($urandom_range(0, 8000), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 65535),
                            $urandom_range(0, 65535), $urandom_range(0, 65535), 0);
                default: set_regs($urandom_range(0, 8000), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 2048));
            endcase
            case (ph % 4)
                0:
                begin
                    in_idle_pct   = 0;
                    out_stall_pct = 0;
                end
                1:
                begin
                    in_idle_pct   = 80;
                    out_stall_pct = 0;
                end
                2:
                begin
                    in_idle_pct   = 0;
                    out_stall_pct = 80;
                end
                default:
                begin
                    in_idle_pct   = 11;
                    out_stall_pct = 11;
                end
            endcase
            send_random(PHASE_BEATS);
        end

        in_valid <= 1'b0;
        @(negedge clk);
        k = 0;
        while (pending != 0 && k < 5000)
        begin
            @(negedge clk);
            k++;
        end
        repeat (SETTLE) @(posedge clk);

        $display("%0d command beats sent over %0d register settings and four handshake mixes;",
                 sent, PHASES + 1);
        $display("%0d wheel-speed beats checked, %0d mismatched, %0d never arrived",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0)
            $display("tb_joystick_teleop_diff_drive: PASS");
        else
            $display("tb_joystick_teleop_diff_drive: FAIL");
        $finish;
    end

endmodule

// File: files.f
hdl/jtdd_pkg.sv
hdl/jtdd_smul.sv
hdl/joystick_teleop_diff_drive.sv
tb/jtdd_rpm_checker.sv
tb/tb_joystick_teleop_diff_drive.sv
